// ===== hw/rtl/i64div_pkg.sv =====
// shared types and constants for the 64-bit integer divider
package i64div_pkg;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned CNT_W  = $clog2(DATA_W);

  // operation codes
  localparam logic [OP_W-1:0] OP_SDIV = 2'd0;
  localparam logic [OP_W-1:0] OP_SREM = 2'd1;
  localparam logic [OP_W-1:0] OP_UDIV = 2'd2;
  localparam logic [OP_W-1:0] OP_UREM = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_FIX
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic step;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_step;
  } sts_t;

endpackage

// ===== hw/rtl/i64div_ifs.sv =====
// item channels of the 64-bit integer divider

interface i64div_in_if;
  logic                             valid;
  logic                             ready;
  logic [i64div_pkg::OP_W-1:0]      op;
  logic [i64div_pkg::DATA_W-1:0]    dividend;
  logic [i64div_pkg::DATA_W-1:0]    divisor;

  modport source (output valid, op, dividend, divisor, input ready);
  modport sink (input valid, op, dividend, divisor, output ready);
endinterface

interface i64div_out_if;
  logic                             valid;
  logic                             ready;
  logic [i64div_pkg::DATA_W-1:0]    value;
  logic                             zero_divisor;

  modport source (output valid, value, zero_divisor, input ready);
  modport sink (input valid, value, zero_divisor, output ready);
endinterface

// ===== hw/rtl/i64div_dpath.sv =====
// datapath of the 64-bit divider: operand registers, restoring step, sign fix-up
module i64div_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  i64div_pkg::cmd_t                cmd_i,
  output i64div_pkg::sts_t                sts_o,
  input  logic [i64div_pkg::OP_W-1:0]     op_i,
  input  logic [i64div_pkg::DATA_W-1:0]   dividend_i,
  input  logic [i64div_pkg::DATA_W-1:0]   divisor_i,
  output logic [i64div_pkg::DATA_W-1:0]   value_o,
  output logic                            zero_divisor_o
);

  localparam int unsigned W = i64div_pkg::DATA_W;

  logic [i64div_pkg::OP_W-1:0]  op_q;
  logic [W-1:0]                 x_q, y_q;
  logic [W-1:0]                 a_q, a_d;
  logic [W-1:0]                 b_q;
  logic [W-1:0]                 r_q, r_d;
  logic                         x_neg_q, y_neg_q, zero_q;
  logic [i64div_pkg::CNT_W-1:0] cnt_q;
  logic [W-1:0]                 value_q;
  logic                         zdiv_q;

  logic         is_signed, want_rem;
  logic [W:0]   rs, diff;
  logic         ge;
  logic [W-1:0] sel, mag_res, fallback, result;
  logic         neg_res;

  assign is_signed = op_q inside {i64div_pkg::OP_SDIV, i64div_pkg::OP_SREM};
  assign want_rem  = op_q inside {i64div_pkg::OP_SREM, i64div_pkg::OP_UREM};

  // one restoring step: shift in next dividend bit, trial subtract
  always_comb begin
    rs   = {r_q, a_q[W-1]};
    diff = rs - {1'b0, b_q};
    ge   = ~diff[W];
    r_d  = ge ? diff[W-1:0] : rs[W-1:0];
    a_d  = {a_q[W-2:0], ge};
  end

  // sign fix-up and zero divisor fallback
  always_comb begin
    sel     = want_rem ? r_q : a_q;
    neg_res = want_rem ? x_neg_q : (x_neg_q ^ y_neg_q);
    mag_res = neg_res ? (W'(0) - sel) : sel;
    if (want_rem) begin
      fallback = x_q;
    end else if (is_signed) begin
      fallback = x_neg_q ? {W{1'b1}} : W'(1);
    end else begin
      fallback = (x_q == '0) ? W'(0) : W'(1);
    end
    result = zero_q ? fallback : mag_res;
  end

  // operand and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i;
      x_q  <= dividend_i;
      y_q  <= divisor_i;
    end
    if (cmd_i.prep) begin
      x_neg_q <= is_signed & x_q[W-1];
      y_neg_q <= is_signed & y_q[W-1];
      zero_q  <= (y_q == '0);
      a_q     <= (is_signed && x_q[W-1]) ? (W'(0) - x_q) : x_q;
      b_q     <= (is_signed && y_q[W-1]) ? (W'(0) - y_q) : y_q;
      r_q     <= '0;
    end else if (cmd_i.step) begin
      a_q <= a_d;
      r_q <= r_d;
    end
    if (cmd_i.finish) begin
      value_q <= result;
      zdiv_q  <= zero_q;
    end
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.prep) begin
      cnt_q <= '0;
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign sts_o.last_step = (cnt_q == i64div_pkg::CNT_W'(W - 1));
  assign value_o         = value_q;
  assign zero_divisor_o  = zdiv_q;

endmodule

// ===== hw/rtl/i64div_ctrl.sv =====
// controller of the 64-bit divider: sequencing and output valid
module i64div_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  i64div_pkg::sts_t  sts_i,
  output i64div_pkg::cmd_t  cmd_o
);

  i64div_pkg::state_e state_q, state_d;
  logic               out_valid_q, out_valid_d;
  logic               out_free;

  assign out_free = ~out_valid_q | out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      i64div_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = i64div_pkg::ST_PREP;
      end
      i64div_pkg::ST_PREP: state_d = i64div_pkg::ST_DIV;
      i64div_pkg::ST_DIV: begin
        if (sts_i.last_step) state_d = i64div_pkg::ST_FIX;
      end
      i64div_pkg::ST_FIX: begin
        if (out_free) state_d = i64div_pkg::ST_IDLE;
      end
      default: state_d = i64div_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      i64div_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      i64div_pkg::ST_PREP: cmd_o.prep = 1'b1;
      i64div_pkg::ST_DIV:  cmd_o.step = 1'b1;
      i64div_pkg::ST_FIX:  cmd_o.finish = out_free;
      default: cmd_o = '0;
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.finish) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= i64div_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/int64_divider_signed_unsigned_core.sv =====
// top level of the 64-bit signed/unsigned integer divider
//
//   channel  dir  payload                       transfer
//   in_i     in   op, dividend, divisor         valid & ready
//   out_o    out  value, zero_divisor           valid & ready
//
// after its item is accepted, a result is formed in order: operand magnitudes,
// 64 restoring steps (one quotient bit each through a single 65-bit
// subtractor), then sign fix-up into the output register.
// a new item is taken in the cycle after the result is written; that result may
// still wait on a stalled output, and the next fix-up holds until it leaves.
// reset clears the controller and step counter only.
module int64_divider_signed_unsigned_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  i64div_in_if.sink     in_i,
  i64div_out_if.source  out_o
);

  i64div_pkg::cmd_t cmd;
  i64div_pkg::sts_t sts;

  // sequencing
  i64div_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // arithmetic
  i64div_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .op_i           (in_i.op),
    .dividend_i     (in_i.dividend),
    .divisor_i      (in_i.divisor),
    .value_o        (out_o.value),
    .zero_divisor_o (out_o.zero_divisor)
  );

endmodule
